// ----- rtl/srfp_pkg.sv -----
// ---------------------------------------------------------------------------
// Servo response frame parser package
// Shared request and response types, command and status codes, frame
// constants and the control and status bundles between controller and
// datapath.
// ---------------------------------------------------------------------------
package srfp_pkg;

	// Request commands.
	localparam logic [1:0] CMD_BYTE   = 2'd0;
	localparam logic [1:0] CMD_RD_RAM = 2'd1;
	localparam logic [1:0] CMD_RD_EEP = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	// Response kinds.
	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	// Verdict status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CHK_BAD  = 2'd1;
	localparam logic [1:0] ST_UNKNOWN  = 2'd2;
	localparam logic [1:0] ST_SIZE_BAD = 2'd3;

	// Frame constants.
	localparam logic [7:0] HDR_BYTE      = 8'hFF;
	localparam logic [7:0] OP_RAM_REPLY  = 8'h44;
	localparam logic [7:0] OP_EEP_REPLY  = 8'h42;
	localparam logic [7:0] OP_STAT_REPLY = 8'h47;
	localparam logic [7:0] CHK_MASK      = 8'hFE;
	localparam logic [7:0] MIN_SIZE      = 8'd7;
	localparam logic [7:0] STAT_MIN_SIZE = 8'd9;
	localparam logic [7:0] REPLY_MIN     = 8'd11;
	localparam logic [8:0] STAT_SLOT     = 9'd48;
	localparam logic [8:0] IDX_ID        = 9'd0;
	localparam logic [8:0] IDX_SIZE      = 9'd4;

	// One request item.
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] rx_byte;
		logic [6:0] read_addr;
	} in_item_t;

	// One response item.
	typedef struct packed {
		logic       kind;
		logic [1:0] status;
		logic [7:0] frame_id;
		logic [7:0] frame_cmd;
		logic [7:0] read_data;
	} out_item_t;

	// Source of the response register.
	typedef enum logic [1:0] {
		OSRC_SIZE_BAD,
		OSRC_VERDICT,
		OSRC_READ
	} out_src_t;

	// Which mirror write the commit sequence performs.
	typedef enum logic [2:0] {
		MW_ID,
		MW_SIZE,
		MW_COPY,
		MW_STAT0,
		MW_STAT1
	} mir_sel_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic     byte_en;
		logic     rd_en;
		logic     out_load;
		out_src_t out_src;
		logic     mir_wr;
		mir_sel_t mir_sel;
		logic     copy_init;
		logic     copy_step;
	} ctl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic size_bad;
		logic frame_end;
		logic commit_reply;
		logic commit_stat;
		logic copy_none;
		logic copy_last;
	} dp_stat_t;

endpackage

// ----- rtl/srfp_datapath.sv -----
// ---------------------------------------------------------------------------
// Servo response frame parser datapath
// Frame field registers, running checksum, payload buffer, the RAM and EEP
// mirror memories with their per-entry valid bits, the copy counters and the
// response register.
// ---------------------------------------------------------------------------
module srfp_datapath
	import srfp_pkg::*;
#(
	parameter int PAYLOAD_DEPTH = 64,
	parameter int RAM_DEPTH     = 128,
	parameter int EEP_DEPTH     = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  req_item,
	input  ctl_cmd_t  ctl,
	output dp_stat_t  stat,
	output out_item_t rsp_item
);

	localparam int PAY_AW = $clog2(PAYLOAD_DEPTH);
	localparam int RAM_AW = $clog2(RAM_DEPTH);
	localparam int EEP_AW = $clog2(EEP_DEPTH);

	localparam logic [7:0] POS_HDR0  = 8'd0;
	localparam logic [7:0] POS_HDR1  = 8'd1;
	localparam logic [7:0] POS_SIZE  = 8'd2;
	localparam logic [7:0] POS_ID    = 8'd3;
	localparam logic [7:0] POS_OP    = 8'd4;
	localparam logic [7:0] POS_CHK1  = 8'd5;
	localparam logic [7:0] POS_CHK2  = 8'd6;
	localparam logic [7:0] POS_DATA  = 8'd7;
	localparam logic [7:0] POS_DATA1 = 8'd8;

	logic [7:0] pos_q;
	logic [7:0] size_q;
	logic [7:0] id_q;
	logic [7:0] op_q;
	logic [7:0] xor_q;
	logic [7:0] chk1_q;
	logic [7:0] chk2_q;
	logic [7:0] data0_q;
	logic [7:0] data1_q;

	logic [7:0] b;
	logic       size_bad;
	logic       frame_end;
	logic [7:0] pay_k;
	logic       pay_wr;
	logic [1:0] verdict;
	logic       op_known;

	logic [7:0]        pay_mem [PAYLOAD_DEPTH];
	logic [7:0]        pay_rd_q;
	logic [7:0]        cp_left_q;
	logic [8:0]        dst_q;
	logic [PAY_AW-1:0] src_q;

	logic [7:0]           ram_mem [RAM_DEPTH];
	logic [RAM_DEPTH-1:0] ram_vld_q;
	logic [7:0]           ram_rd_q;
	logic                 ram_rdv_q;
	logic [7:0]           eep_mem [EEP_DEPTH];
	logic [EEP_DEPTH-1:0] eep_vld_q;
	logic [7:0]           eep_rd_q;
	logic                 eep_rdv_q;
	logic                 rd_eep_q;

	logic [8:0]        rd_ext;
	logic              rd_ram_ok;
	logic              rd_eep_ok;
	logic [RAM_AW-1:0] rd_ram_idx;
	logic [EEP_AW-1:0] rd_eep_idx;
	logic [7:0]        rd_value;

	logic [8:0] wr_addr;
	logic [7:0] wr_data;
	logic       wr_eep;
	logic       ram_we;
	logic       eep_we;

	out_item_t rsp_q;

	// Byte decode against the current frame position.
	assign b         = req_item.rx_byte;
	assign size_bad  = (pos_q == POS_SIZE) &&
		((b < MIN_SIZE) || (9'(b) > (9'(MIN_SIZE) + 9'(PAYLOAD_DEPTH))));
	assign frame_end = (pos_q >= POS_ID) && ((9'(pos_q) + 9'd1) >= 9'(size_q));
	assign pay_k     = pos_q - POS_DATA;
	assign pay_wr    = ctl.byte_en && (pos_q >= POS_DATA) &&
		(9'(pay_k) < 9'(PAYLOAD_DEPTH));

	// Frame field capture and position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_HDR0;
			size_q  <= '0;
			id_q    <= '0;
			op_q    <= '0;
			xor_q   <= '0;
			chk1_q  <= '0;
			chk2_q  <= '0;
			data0_q <= '0;
			data1_q <= '0;
		end else if (ctl.byte_en) begin
			unique case (pos_q)
				POS_HDR0: begin
					if (b == HDR_BYTE) pos_q <= POS_HDR1;
				end
				POS_HDR1: begin
					pos_q <= (b == HDR_BYTE) ? POS_SIZE : POS_HDR0;
				end
				POS_SIZE: begin
					if (size_bad) begin
						pos_q <= POS_HDR0;
					end else begin
						size_q <= b;
						xor_q  <= b;
						pos_q  <= POS_ID;
					end
				end
				POS_ID: begin
					id_q  <= b;
					xor_q <= xor_q ^ b;
				end
				POS_OP: begin
					op_q  <= b;
					xor_q <= xor_q ^ b;
				end
				POS_CHK1: begin
					chk1_q <= b;
				end
				POS_CHK2: begin
					chk2_q <= b;
				end
				default: begin
					xor_q <= xor_q ^ b;
					if (pos_q == POS_DATA) data0_q <= b;
					if (pos_q == POS_DATA1) data1_q <= b;
				end
			endcase
			if (pos_q >= POS_ID) begin
				pos_q <= frame_end ? POS_HDR0 : pos_q + 8'd1;
			end
		end
	end

	// Payload buffer: written as data bytes arrive, read back during the copy.
	always_ff @(posedge clk) begin
		if (pay_wr) pay_mem[pay_k[PAY_AW-1:0]] <= b;
		pay_rd_q <= pay_mem[src_q];
	end

	// Verdict from the completed frame fields.
	assign op_known = (op_q == OP_RAM_REPLY) || (op_q == OP_EEP_REPLY) ||
		(op_q == OP_STAT_REPLY);

	always_comb begin
		if (!op_known) begin
			verdict = ST_UNKNOWN;
		end else if ((op_q == OP_STAT_REPLY) && (size_q < STAT_MIN_SIZE)) begin
			verdict = ST_SIZE_BAD;
		end else if ((chk1_q != (xor_q & CHK_MASK)) || (chk2_q != (~xor_q & CHK_MASK))) begin
			verdict = ST_CHK_BAD;
		end else begin
			verdict = ST_OK;
		end
	end

	// Copy counters for the register bytes of a read reply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_left_q <= '0;
			dst_q     <= '0;
			src_q     <= '0;
		end else if (ctl.copy_init) begin
			cp_left_q <= (size_q > REPLY_MIN) ? size_q - REPLY_MIN : 8'd0;
			dst_q     <= {1'b0, data0_q};
			src_q     <= PAY_AW'(2);
		end else if (ctl.copy_step) begin
			cp_left_q <= cp_left_q - 8'd1;
			dst_q     <= dst_q + 9'd1;
			src_q     <= src_q + PAY_AW'(1);
		end
	end

	// Mirror write selection.
	assign wr_eep = (ctl.mir_sel != MW_STAT0) && (ctl.mir_sel != MW_STAT1) &&
		(op_q == OP_EEP_REPLY);

	always_comb begin
		unique case (ctl.mir_sel)
			MW_ID: begin
				wr_addr = IDX_ID;
				wr_data = id_q;
			end
			MW_SIZE: begin
				wr_addr = IDX_SIZE;
				wr_data = size_q;
			end
			MW_COPY: begin
				wr_addr = dst_q;
				wr_data = pay_rd_q;
			end
			MW_STAT0: begin
				wr_addr = STAT_SLOT;
				wr_data = data0_q;
			end
			MW_STAT1: begin
				wr_addr = STAT_SLOT + 9'd1;
				wr_data = data1_q;
			end
			default: begin
				wr_addr = IDX_ID;
				wr_data = id_q;
			end
		endcase
	end

	// Entries past the mirror end are dropped.
	assign ram_we = ctl.mir_wr && !wr_eep && (wr_addr < 9'(RAM_DEPTH));
	assign eep_we = ctl.mir_wr && wr_eep && (wr_addr < 9'(EEP_DEPTH));

	// Mirror read addressing; entries past the end read as zero.
	assign rd_ext     = 9'(req_item.read_addr);
	assign rd_ram_ok  = rd_ext < 9'(RAM_DEPTH);
	assign rd_eep_ok  = rd_ext < 9'(EEP_DEPTH);
	assign rd_ram_idx = rd_ext[RAM_AW-1:0];
	assign rd_eep_idx = rd_ext[EEP_AW-1:0];

	// RAM mirror memory.
	always_ff @(posedge clk) begin
		if (ram_we) ram_mem[wr_addr[RAM_AW-1:0]] <= wr_data;
		ram_rd_q <= ram_mem[rd_ram_idx];
	end

	// EEP mirror memory.
	always_ff @(posedge clk) begin
		if (eep_we) eep_mem[wr_addr[EEP_AW-1:0]] <= wr_data;
		eep_rd_q <= eep_mem[rd_eep_idx];
	end

	// Valid bits: an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_vld_q <= '0;
			eep_vld_q <= '0;
			ram_rdv_q <= 1'b0;
			eep_rdv_q <= 1'b0;
			rd_eep_q  <= 1'b0;
		end else begin
			if (ram_we) ram_vld_q[wr_addr[RAM_AW-1:0]] <= 1'b1;
			if (eep_we) eep_vld_q[wr_addr[EEP_AW-1:0]] <= 1'b1;
			ram_rdv_q <= rd_ram_ok && ram_vld_q[rd_ram_idx];
			eep_rdv_q <= rd_eep_ok && eep_vld_q[rd_eep_idx];
			if (ctl.rd_en) rd_eep_q <= (req_item.cmd == CMD_RD_EEP);
		end
	end

	always_comb begin
		if (rd_eep_q) begin
			rd_value = eep_rdv_q ? eep_rd_q : 8'd0;
		end else begin
			rd_value = ram_rdv_q ? ram_rd_q : 8'd0;
		end
	end

	// Response register.
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			unique case (ctl.out_src)
				OSRC_SIZE_BAD: begin
					rsp_q <= '{kind: KIND_VERDICT, status: ST_SIZE_BAD, frame_id: 8'd0,
						frame_cmd: 8'd0, read_data: 8'd0};
				end
				OSRC_VERDICT: begin
					rsp_q <= '{kind: KIND_VERDICT, status: verdict, frame_id: id_q,
						frame_cmd: op_q, read_data: 8'd0};
				end
				OSRC_READ: begin
					rsp_q <= '{kind: KIND_READ, status: ST_OK, frame_id: 8'd0,
						frame_cmd: 8'd0, read_data: rd_value};
				end
				default: begin
					rsp_q <= '{kind: KIND_VERDICT, status: ST_SIZE_BAD, frame_id: 8'd0,
						frame_cmd: 8'd0, read_data: 8'd0};
				end
			endcase
		end
	end

	assign rsp_item = rsp_q;

	// Status towards the controller.
	assign stat.size_bad     = size_bad;
	assign stat.frame_end    = frame_end;
	assign stat.commit_reply = (verdict == ST_OK) &&
		((op_q == OP_RAM_REPLY) || (op_q == OP_EEP_REPLY));
	assign stat.commit_stat  = (verdict == ST_OK) && (op_q == OP_STAT_REPLY);
	assign stat.copy_none    = size_q <= REPLY_MIN;
	assign stat.copy_last    = cp_left_q == 8'd1;

endmodule

// ----- rtl/srfp_ctrl.sv -----
// ---------------------------------------------------------------------------
// Servo response frame parser controller
// Request and response handshakes, mirror read timing and the commit
// sequence that updates the mirrors after a good reply.
// ---------------------------------------------------------------------------
module srfp_ctrl
	import srfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] req_cmd,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  dp_stat_t   stat,
	output ctl_cmd_t   ctl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_FINISH,
		S_WR_ID,
		S_WR_SIZE,
		S_COPY_RD,
		S_COPY_WR,
		S_STAT0,
		S_STAT1
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   acc;
	logic   acc_read;

	// A request is taken only when idle and the response slot is free or draining.
	assign req_ready = (state_q == S_IDLE) && (!out_valid_q || rsp_ready);
	assign acc       = req_valid && req_ready;
	assign acc_read  = acc && ((req_cmd == CMD_RD_RAM) || (req_cmd == CMD_RD_EEP));
	assign rsp_valid = out_valid_q;

	// Commands to the datapath.
	always_comb begin
		ctl           = '0;
		ctl.out_src   = OSRC_VERDICT;
		ctl.mir_sel   = MW_ID;
		ctl.byte_en   = acc && (req_cmd == CMD_BYTE);
		ctl.rd_en     = acc_read;
		if (ctl.byte_en && stat.size_bad) begin
			ctl.out_load = 1'b1;
			ctl.out_src  = OSRC_SIZE_BAD;
		end
		unique case (state_q)
			S_IDLE: begin
			end
			S_READ: begin
				ctl.out_load = 1'b1;
				ctl.out_src  = OSRC_READ;
			end
			S_FINISH: begin
				ctl.out_load = 1'b1;
				ctl.out_src  = OSRC_VERDICT;
			end
			S_WR_ID: begin
				ctl.mir_wr  = 1'b1;
				ctl.mir_sel = MW_ID;
			end
			S_WR_SIZE: begin
				ctl.mir_wr    = 1'b1;
				ctl.mir_sel   = MW_SIZE;
				ctl.copy_init = 1'b1;
			end
			S_COPY_RD: begin
			end
			S_COPY_WR: begin
				ctl.mir_wr    = 1'b1;
				ctl.mir_sel   = MW_COPY;
				ctl.copy_step = 1'b1;
			end
			S_STAT0: begin
				ctl.mir_wr  = 1'b1;
				ctl.mir_sel = MW_STAT0;
			end
			S_STAT1: begin
				ctl.mir_wr  = 1'b1;
				ctl.mir_sel = MW_STAT1;
			end
			default: begin
			end
		endcase
	end

	// State and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_read) begin
						state_q <= S_READ;
					end else if (ctl.byte_en && stat.frame_end) begin
						state_q <= S_FINISH;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				S_FINISH: begin
					if (stat.commit_reply) begin
						state_q <= S_WR_ID;
					end else if (stat.commit_stat) begin
						state_q <= S_STAT0;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_WR_ID: begin
					state_q <= S_WR_SIZE;
				end
				S_WR_SIZE: begin
					state_q <= stat.copy_none ? S_IDLE : S_COPY_RD;
				end
				S_COPY_RD: begin
					state_q <= S_COPY_WR;
				end
				S_COPY_WR: begin
					state_q <= stat.copy_last ? S_IDLE : S_COPY_RD;
				end
				S_STAT0: begin
					state_q <= S_STAT1;
				end
				S_STAT1: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The response register is never reloaded while it holds an untaken item.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || rsp_ready))
		else $error("response register overwritten");

	// A mirror read delivers its response: acceptance moves the controller to S_READ, which loads the response register.
	a_read_returns: assert property (@(posedge clk) disable iff (!arst_n)
		acc_read |=> ##1 out_valid_q)
		else $error("mirror read gave no response");

	// The last byte of a frame always leads to the verdict state.
	a_frame_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.byte_en && stat.frame_end) |=> (state_q == S_FINISH))
		else $error("frame end missed");

	// The response slot is empty when the verdict is loaded.
	a_finish_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |-> !out_valid_q)
		else $error("verdict slot busy");
`endif

endmodule

// ----- rtl/servo_response_frame_parser_top.sv -----
// ---------------------------------------------------------------------------
// Servo response frame parser
// Takes received servo bytes one request at a time, hunts for the FF FF
// header, checks both frame checksums and gives a verdict at frame end (or
// at once on a bad size byte). Good RAM-read and EEP-read replies are copied
// into the RAM or EEP mirror, and a good STAT reply stores its two status
// bytes at RAM mirror entries 48 and 49. Mirror entries can be read back
// with a read request, answered from the registered mirror memory read.
// After the last byte of a frame the block gives its verdict; then for a
// good RAM or EEP reply it writes the ID and size entries and, when size is
// above 11, size - 11 copied bytes, and for a good STAT reply its two status
// bytes, all through the mirror's single write port, during which no request
// is taken. The mirrors read as zero after reset through per-entry valid
// bits, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module servo_response_frame_parser_top
	import srfp_pkg::*;
#(
	parameter int PAYLOAD_DEPTH = 64,
	parameter int RAM_DEPTH     = 128,
	parameter int EEP_DEPTH     = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req_item,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp_item
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	// Controller.
	srfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_cmd   (req_item.cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Datapath.
	srfp_datapath #(
		.PAYLOAD_DEPTH (PAYLOAD_DEPTH),
		.RAM_DEPTH     (RAM_DEPTH),
		.EEP_DEPTH     (EEP_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_item (req_item),
		.ctl      (ctl),
		.stat     (stat),
		.rsp_item (rsp_item)
	);

endmodule
